@@ rtl/core/lffs_pkg.sv @@
// ----------------------------------------------------------------------------
// lffs_pkg
// Shared types and constants for the length-field frame splitter.
// ----------------------------------------------------------------------------
package lffs_pkg;

  // Result status codes
  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_SHORT   = 3'd1,
    ST_LONG    = 3'd2,
    ST_BAD_CFG = 3'd3,
    ST_HALTED  = 3'd4
  } status_t;

  // Length field width codes
  localparam logic [1:0] WC_2B = 2'd0;
  localparam logic [1:0] WC_4B = 2'd1;
  localparam logic [1:0] WC_8B = 2'd2;

  // Register indexes (byte address / 4)
  localparam logic [2:0] REG_HDR_BYTES     = 3'd0;
  localparam logic [2:0] REG_LEN_POS       = 3'd1;
  localparam logic [2:0] REG_WIDTH_CODE    = 3'd2;
  localparam logic [2:0] REG_MSB_FIRST     = 3'd3;
  localparam logic [2:0] REG_COUNTS_HEADER = 3'd4;
  localparam logic [2:0] REG_MAX_FRAME     = 3'd5;

  typedef struct packed {
    logic [7:0]  hdr_bytes;
    logic [7:0]  len_pos;
    logic [1:0]  length_width_code;
    logic        msb_first;
    logic        length_counts_header;
    logic [31:0] max_frame_bytes;
  } cfg_t;

  typedef struct packed {
    logic [7:0] byte_out;
    logic       frame_start;
    logic       frame_end;
    status_t    status;
  } res_t;

  // Field width in bytes, zero for the invalid code
  function automatic logic [3:0] field_width(input logic [1:0] code);
    logic [3:0] w;
    case (code)
      WC_2B:   w = 4'd2;
      WC_4B:   w = 4'd4;
      WC_8B:   w = 4'd8;
      default: w = 4'd0;
    endcase
    return w;
  endfunction

endpackage

@@ rtl/core/lffs_tracker.sv @@
// ----------------------------------------------------------------------------
// lffs_tracker
// Frame position tracking, length field capture and size checks, one byte
// per step.
// ----------------------------------------------------------------------------
module lffs_tracker import lffs_pkg::*; #(
  parameter int unsigned POSITION_BITS = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] data_byte,
  input  cfg_t       cfg,
  output res_t       res
);

  localparam int XW = (POSITION_BITS > 32) ? POSITION_BITS : 33;
  localparam logic [64:0] POS_LIMIT = 65'd1 << POSITION_BITS;

  logic [POSITION_BITS-1:0] pos_r, pos_nxt;
  logic [63:0]              acc_r, acc_nxt;
  logic [31:0]              fb_r, fb_nxt;
  logic                     halted_r, halted_nxt;

  logic [3:0]    fw;
  logic          cfg_bad;
  logic [XW-1:0] pos_x, off_x, rel, hs_m1_x, fb_x;
  logic          in_field;
  logic [63:0]   acc_base, acc_new, size;
  logic [64:0]   sum65;
  logic          over, short_sz, long_sz, tail_end;
  logic [POSITION_BITS-1:0] pos_inc;

  always_comb begin
    fw       = field_width(cfg.length_width_code);
    cfg_bad  = (cfg.hdr_bytes == 8'd0) || (fw == 4'd0) ||
               (({1'b0, cfg.len_pos} + {5'd0, fw}) > {1'b0, cfg.hdr_bytes}) ||
               (cfg.max_frame_bytes < {24'd0, cfg.hdr_bytes});
    pos_x    = XW'(pos_r);
    pos_inc  = pos_r + POSITION_BITS'(1);
    off_x    = XW'(cfg.len_pos);
    rel      = pos_x - off_x;
    in_field = (pos_x >= off_x) && (rel < XW'(fw));
    acc_base = (pos_r == '0) ? 64'd0 : acc_r;
    if (!in_field) begin
      acc_new = acc_base;
    end else if (cfg.msb_first) begin
      acc_new = {acc_base[55:0], data_byte};
    end else begin
      acc_new = acc_base | (64'(data_byte) << {rel[2:0], 3'b000});
    end
    hs_m1_x  = XW'(cfg.hdr_bytes - 8'd1);
    sum65    = {1'b0, acc_new} + 65'(cfg.hdr_bytes);
    over     = !cfg.length_counts_header && sum65[64];
    size     = cfg.length_counts_header ? acc_new : sum65[63:0];
    short_sz = !over && (size < 64'(cfg.hdr_bytes));
    long_sz  = over || (size > 64'(cfg.max_frame_bytes)) || ({1'b0, size} > POS_LIMIT);
    fb_x     = XW'(fb_r);
    tail_end = (fb_r == 32'd0) || (pos_x >= fb_x - XW'(1));

    res.byte_out    = data_byte;
    res.frame_start = 1'b0;
    res.frame_end   = 1'b0;
    res.status      = ST_OK;
    pos_nxt    = pos_r;
    acc_nxt    = acc_r;
    fb_nxt     = fb_r;
    halted_nxt = halted_r;

    if (halted_r) begin
      res.status = ST_HALTED;
    end else if (cfg_bad) begin
      res.status = ST_BAD_CFG;
      halted_nxt = 1'b1;
    end else begin
      res.frame_start = (pos_r == '0);
      acc_nxt         = acc_new;
      if (pos_x < hs_m1_x) begin
        pos_nxt = pos_inc;
      end else if (pos_x == hs_m1_x) begin
        if (short_sz) begin
          res.status = ST_SHORT;
          halted_nxt = 1'b1;
        end else if (long_sz) begin
          res.status = ST_LONG;
          halted_nxt = 1'b1;
        end else begin
          fb_nxt = size[31:0];
          if (size == 64'(cfg.hdr_bytes)) begin
            res.frame_end = 1'b1;
            pos_nxt       = '0;
          end else begin
            pos_nxt = pos_inc;
          end
        end
      end else if (tail_end) begin
        res.frame_end = 1'b1;
        pos_nxt       = '0;
      end else begin
        pos_nxt = pos_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      acc_r    <= '0;
      fb_r     <= '0;
      halted_r <= 1'b0;
    end else if (step) begin
      pos_r    <= pos_nxt;
      acc_r    <= acc_nxt;
      fb_r     <= fb_nxt;
      halted_r <= halted_nxt;
    end
  end

  // Halt is sticky
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r |=> halted_r)
    else $error("halt latch dropped");

  // Frame end rewinds the position
  a_end_rewinds: assert property (@(posedge clk) disable iff (!rst_n)
    (step && res.frame_end) |=> (pos_r == '0))
    else $error("position not cleared after frame end");

  // A bad configuration halts the block
  a_bad_cfg_halts: assert property (@(posedge clk) disable iff (!rst_n)
    (step && !halted_r && cfg_bad) |=> halted_r)
    else $error("bad configuration did not halt");

endmodule

@@ rtl/core/length_field_frame_splitter_core.sv @@
// ----------------------------------------------------------------------------
// length_field_frame_splitter_core
// Cuts a byte stream into length-field framed messages and marks each byte.
// ----------------------------------------------------------------------------
// Path: input register -> tracker -> output register, which drives out_tvalid.
// Throughput: 1 byte per cycle while out_tready holds; the tracker's
//   position/length loop keeps pace, so the next byte follows right behind.
// Reset (rst_n, synchronous): position, length, frame size and the error latch
//   clear, registers take their documented defaults, both channels go empty.
module length_field_frame_splitter_core import lffs_pkg::*; #(
  parameter int unsigned POSITION_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,     // [7:0] data_byte
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,    // [7:0] byte_out
  output logic        out_tlast,    // frame_end
  output logic [3:0]  out_tuser,    // [0] frame_start, [3:1] status
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  cfg_t       cfg_r;
  logic       cfg_wr;
  logic [2:0] cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[4:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hdr_bytes            <= 8'd4;
      cfg_r.len_pos              <= 8'd0;
      cfg_r.length_width_code    <= WC_4B;
      cfg_r.msb_first            <= 1'b1;
      cfg_r.length_counts_header <= 1'b0;
      cfg_r.max_frame_bytes      <= 32'd65536;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_HDR_BYTES:     cfg_r.hdr_bytes            <= cfg_pwdata[7:0];
        REG_LEN_POS:       cfg_r.len_pos              <= cfg_pwdata[7:0];
        REG_WIDTH_CODE:    cfg_r.length_width_code    <= cfg_pwdata[1:0];
        REG_MSB_FIRST:     cfg_r.msb_first            <= cfg_pwdata[0];
        REG_COUNTS_HEADER: cfg_r.length_counts_header <= cfg_pwdata[0];
        REG_MAX_FRAME:     cfg_r.max_frame_bytes      <= cfg_pwdata;
        default: ;  // unmapped: write dropped
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_HDR_BYTES:     cfg_prdata = {24'd0, cfg_r.hdr_bytes};
      REG_LEN_POS:       cfg_prdata = {24'd0, cfg_r.len_pos};
      REG_WIDTH_CODE:    cfg_prdata = {30'd0, cfg_r.length_width_code};
      REG_MSB_FIRST:     cfg_prdata = {31'd0, cfg_r.msb_first};
      REG_COUNTS_HEADER: cfg_prdata = {31'd0, cfg_r.length_counts_header};
      REG_MAX_FRAME:     cfg_prdata = cfg_r.max_frame_bytes;
      default:           cfg_prdata = 32'd0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Input register -> tracker -> output register
  // The input stage frees itself whenever its beat moves into the output
  // register, so a new beat is taken while a result still waits downstream.
  // --------------------------------------------------------------------------
  logic       in_valid_r;
  logic [7:0] in_data_r;
  logic       out_valid_r;
  res_t       res, res_r;
  logic       proc_go;
  logic       in_fire;

  assign proc_go   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || proc_go;
  assign in_fire   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_fire) begin
      in_valid_r <= 1'b1;
    end else if (proc_go) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_data_r <= in_tdata;
    end
  end

  lffs_tracker #(
    .POSITION_BITS (POSITION_BITS)
  ) u_tracker (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (proc_go),
    .data_byte (in_data_r),
    .cfg       (cfg_r),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (proc_go) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (proc_go) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = res_r.byte_out;
  assign out_tlast  = res_r.frame_end;
  assign out_tuser  = {res_r.status, res_r.frame_start};

  // A processed beat always lands in the output register
  a_proc_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    proc_go |=> out_valid_r)
    else $error("processed beat lost");

  // An accepted beat is held in the input stage
  a_in_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> in_valid_r)
    else $error("accepted beat not held");

  // End marks only ride on good beats
  a_marks_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.frame_end) |-> (res_r.status == ST_OK))
    else $error("frame end on an error beat");

endmodule

@@ tb/length_field_frame_splitter_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// length_field_frame_splitter_core_tb
// Streams length-field framed byte traffic through the splitter over a series
// of register settings. Every result beat is checked field by field against
// a local frame tracker. The run closes with one error kind picked at random,
// followed by beats in the latched error state.
// ----------------------------------------------------------------------------
module length_field_frame_splitter_core_tb;
  import lffs_pkg::*;

  // Width code the block must reject, and a register slot with no register
  localparam logic [1:0] WC_NONE   = 2'd3;
  localparam logic [2:0] REG_SPARE = 3'd6;

  // Random item count, and the point after which idling stops
  localparam int unsigned RANDOM_BYTES = 1150;
  localparam int unsigned QUIET_TAIL  = 900;

  // How the run is brought to its sticky error at the end
  typedef enum int {
    END_SHORT,        // size below header size
    END_LONG,         // size above the maximum
    END_WRAP,         // header plus 64-bit length wraps around
    END_BAD_SETTING   // register combination the block rejects
  } ending_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;

  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'd0;      // [7:0] data_byte

  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;            // [7:0] byte_out
  logic        out_tlast;            // frame_end
  logic [3:0]  out_tuser;            // [0] frame_start, [3:1] status

  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [4:0]  cfg_paddr = 5'd0;
  logic [31:0] cfg_pwdata = 32'd0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  length_field_frame_splitter_core u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Frame tracker state: register mirror plus position, gathered length,
  // frame size and the sticky error latch.
  // --------------------------------------------------------------------------
  localparam cfg_t SETTING_AT_RESET = '{
    hdr_bytes:            8'd4,
    len_pos:              8'd0,
    length_width_code:    WC_4B,
    msb_first:            1'b1,
    length_counts_header: 1'b0,
    max_frame_bytes:      32'd65536
  };

  cfg_t        cfg_shadow = SETTING_AT_RESET;
  logic [31:0] frame_pos = '0;
  logic [63:0] len_gathered = '0;
  logic [31:0] frame_total = '0;
  logic        locked_up = 1'b0;

  logic [7:0]  pending_bytes[$];     // bytes not yet offered to the block
  res_t        expected_beats[$];    // results owed for accepted bytes

  int unsigned in_gap_pct = 25;
  int unsigned out_stall_pct = 25;
  int unsigned in_gap_left = 0;
  int unsigned out_stall_left = 0;

  int unsigned mismatches = 0;
  int unsigned beats_checked = 0;
  int unsigned frames_closed = 0;
  int unsigned halted_beats = 0;
  int unsigned settings_done = 0;

  function automatic int unsigned lane_bytes(input logic [1:0] code);
    return (code == WC_8B) ? 8 : (code == WC_4B) ? 4 : (code == WC_2B) ? 2 : 0;
  endfunction

  // Advance the tracker by one byte and return the result it owes.
  function automatic res_t split_predict(input logic [7:0] b);
    res_t        r;
    logic [63:0] p;
    logic [63:0] hs;
    logic [63:0] off;
    logic [63:0] w;
    logic [64:0] total;
    r.byte_out    = b;
    r.frame_start = 1'b0;
    r.frame_end   = 1'b0;
    r.status      = ST_OK;
    p   = {32'd0, frame_pos};
    hs  = 64'(cfg_shadow.hdr_bytes);
    off = 64'(cfg_shadow.len_pos);
    w   = 64'(lane_bytes(cfg_shadow.length_width_code));
    // once latched, bytes only pass through
    if (locked_up) begin
      r.status = ST_HALTED;
      return r;
    end
    // register sanity is rechecked on every byte
    if (hs == 0 || w == 0 || off + w > hs || 64'(cfg_shadow.max_frame_bytes) < hs) begin
      locked_up = 1'b1;
      r.status  = ST_BAD_CFG;
      return r;
    end
    r.frame_start = (p == 0);
    if (p == 0) len_gathered = '0;
    if (p >= off && p < off + w) begin
      if (cfg_shadow.msb_first)
        len_gathered = {len_gathered[55:0], b};
      else
        len_gathered = len_gathered | (64'(b) << (8 * ((p - off) & 7)));
    end
    if (p < hs - 1) begin
      frame_pos = frame_pos + 1;
    end else if (p == hs - 1) begin
      // last header byte: size is settled here; bit 64 flags a wrapped sum
      total = cfg_shadow.length_counts_header ? {1'b0, len_gathered} :
              {1'b0, hs} + {1'b0, len_gathered};
      if (!total[64] && total[63:0] < hs)
        r.status = ST_SHORT;
      else if (total[64] || total[63:0] > 64'(cfg_shadow.max_frame_bytes))
        r.status = ST_LONG;
      if (r.status != ST_OK) begin
        locked_up = 1'b1;
      end else begin
        frame_total = total[31:0];
        if (total[63:0] == hs) begin
          r.frame_end = 1'b1;
          frame_pos   = '0;
        end else begin
          frame_pos = frame_pos + 1;
        end
      end
    end else if (frame_total == 0 || p >= {32'd0, frame_total} - 1) begin
      r.frame_end = 1'b1;
      frame_pos   = '0;
    end else begin
      frame_pos = frame_pos + 1;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch at beat %0d: %s got %0h want %0h", beats_checked, what, got, want);
    mismatches++;
  endtask

  // --------------------------------------------------------------------------
  // Register mirror: follows every completed APB write.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      cfg_shadow = SETTING_AT_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
      case (cfg_paddr[4:2])
        REG_HDR_BYTES:     cfg_shadow.hdr_bytes            = cfg_pwdata[7:0];
        REG_LEN_POS:       cfg_shadow.len_pos              = cfg_pwdata[7:0];
        REG_WIDTH_CODE:    cfg_shadow.length_width_code    = cfg_pwdata[1:0];
        REG_MSB_FIRST:     cfg_shadow.msb_first            = cfg_pwdata[0];
        REG_COUNTS_HEADER: cfg_shadow.length_counts_header = cfg_pwdata[0];
        REG_MAX_FRAME:     cfg_shadow.max_frame_bytes      = cfg_pwdata;
        default: ;         // unmapped slots are ignored by the block too
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Input driver: feeds pending_bytes one beat at a time, with random idle
  // bursts. Each accepted beat is run through the tracker right away.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid    <= 1'b0;
      in_gap_left  = 0;
      frame_pos    = '0;
      len_gathered = '0;
      frame_total  = '0;
      locked_up    = 1'b0;
    end else begin
      if (in_tvalid && in_tready)
        expected_beats.push_back(split_predict(in_tdata));
      if (!in_tvalid || in_tready) begin
        if (in_gap_left != 0) begin
          in_tvalid <= 1'b0;
          in_gap_left--;
        end else if (pending_bytes.size() != 0 && $urandom_range(0, 99) < in_gap_pct) begin
          in_tvalid   <= 1'b0;
          in_gap_left = $urandom_range(0, 3);
        end else if (pending_bytes.size() != 0) begin
          in_tvalid <= 1'b1;
          in_tdata  <= pending_bytes.pop_front();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor: checks each accepted beat against the oldest expectation
  // and throttles out_tready in bursts.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    res_t want;
    if (!rst_n) begin
      out_tready     <= 1'b0;
      out_stall_left = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_beats.size() == 0) begin
          report_mismatch("beat with nothing owed, byte", out_tdata, 0);
        end else begin
          want = expected_beats.pop_front();
          if (out_tdata !== want.byte_out)
            report_mismatch("byte_out", out_tdata, want.byte_out);
          if (out_tuser[0] !== want.frame_start)
            report_mismatch("frame_start", out_tuser[0], want.frame_start);
          if (out_tlast !== want.frame_end)
            report_mismatch("frame_end", out_tlast, want.frame_end);
          if (out_tuser[3:1] !== want.status)
            report_mismatch("status", out_tuser[3:1], want.status);
          beats_checked++;
          if (want.frame_end) frames_closed++;
          if (want.status == ST_HALTED) halted_beats++;
        end
      end
      if (out_stall_left != 0) begin
        out_tready <= 1'b0;
        out_stall_left--;
      end else if ($urandom_range(0, 99) < out_stall_pct) begin
        out_tready     <= 1'b0;
        out_stall_left = $urandom_range(0, 3);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic apb_write(input logic [2:0] idx, input logic [31:0] value);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic program_setting(input logic [7:0] hs, input logic [7:0] off,
                                 input logic [1:0] code, input logic big,
                                 input logic counts, input logic [31:0] cap);
    apb_write(REG_HDR_BYTES, 32'(hs));
    apb_write(REG_LEN_POS, 32'(off));
    apb_write(REG_WIDTH_CODE, 32'(code));
    apb_write(REG_MSB_FIRST, 32'(big));
    apb_write(REG_COUNTS_HEADER, 32'(counts));
    apb_write(REG_MAX_FRAME, cap);
    settings_done++;
  endtask

  // Queue one frame under the current setting: header with the length field
  // placed by offset and byte order, then the body. fill < 0 means random.
  task automatic add_frame(input logic [63:0] field, input int unsigned body_len,
                           input int fill);
    int unsigned hs;
    int unsigned off;
    int unsigned w;
    int unsigned k;
    logic [7:0]  b;
    hs  = cfg_shadow.hdr_bytes;
    off = cfg_shadow.len_pos;
    w   = lane_bytes(cfg_shadow.length_width_code);
    for (int unsigned i = 0; i < hs + body_len; i++) begin
      b = (fill < 0) ? 8'($urandom) : 8'(fill);
      if (i >= off && i < off + w) begin
        k = cfg_shadow.msb_first ? off + w - 1 - i : i - off;
        b = 8'(field >> (8 * k));
      end
      pending_bytes.push_back(b);
    end
  endtask

  // Block is idle once every queued byte has gone in and come back out.
  task automatic wait_drain();
    do @(negedge clk);
    while (pending_bytes.size() != 0 || in_tvalid || expected_beats.size() != 0);
  endtask

  function automatic int unsigned idle_share();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 15;
      default: return 40;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    logic [7:0]  held[$];
    ending_t     ending;
    int unsigned phase_no;
    int unsigned random_bytes;
    int unsigned hs;
    int unsigned off;
    int unsigned w;
    int unsigned body;
    int unsigned n;
    int unsigned budget;
    logic [1:0]  code;
    logic [31:0] cap;
    logic [63:0] room;

    phase_no     = 0;
    random_bytes = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part under the reset setting (4-byte header, 4-byte big-endian
    // length, length excludes header, max 65536).
    add_frame(64'd0, 0, 8'h00);      // header-only frame, all-zero bytes
    add_frame(64'd1, 1, 8'hFF);      // one-byte body of all ones
    add_frame(64'd5, 5, -1);
    // hold back the last three body bytes: registers change mid-frame
    repeat (3) held.push_front(pending_bytes.pop_back());
    wait_drain();
    apb_write(REG_MSB_FIRST, 32'd0);
    apb_write(REG_COUNTS_HEADER, 32'd1);
    apb_write(REG_SPARE, $urandom);  // unmapped slot, must have no effect
    @(negedge clk);
    while (held.size() != 0) pending_bytes.push_back(held.pop_front());
    // next frame picks up little-endian, length counting the header
    add_frame(64'd6, 2, -1);

    // Random part: a fresh register setting per phase, whole frames only.
    // The first phases pin the extremes: smallest header with max equal to
    // the header, largest header with the field at its last slot, 8-byte field.
    while (random_bytes < RANDOM_BYTES) begin
      phase_no++;
      wait_drain();
      code = (phase_no == 3) ? WC_8B : (phase_no <= 2) ? WC_2B : 2'($urandom_range(0, 2));
      w = lane_bytes(code);
      if (phase_no == 1) begin
        hs  = 2;
        off = 0;
        cap = 32'd2;
      end else if (phase_no == 2) begin
        hs  = 255;
        off = 253;
        cap = 32'hFFFF_FFFF;
      end else begin
        hs  = ($urandom_range(0, 3) == 0) ? $urandom_range(w, 40) : $urandom_range(w, 12);
        off = $urandom_range(0, hs - w);
        case ($urandom_range(0, 3))
          0:       cap = hs;
          1:       cap = hs + $urandom_range(1, 30);
          2:       cap = 32'hFFFF_FFFF;
          default: cap = $urandom_range(hs, 32'hFFFF_FFFE);
        endcase
      end
      program_setting(8'(hs), 8'(off), code, 1'($urandom), 1'($urandom), cap);
      @(negedge clk);
      in_gap_pct    = (random_bytes > QUIET_TAIL) ? 0 : idle_share();
      out_stall_pct = (random_bytes > QUIET_TAIL) ? 0 : idle_share();
      budget = (hs > 200) ? 1 : $urandom_range(60, 160);
      n = 0;
      do begin
        room = 64'(cap) - 64'(hs);
        if (room > 24) room = 24;
        body = $urandom_range(0, 32'(room));
        add_frame(cfg_shadow.length_counts_header ? 64'(hs + body) : 64'(body), body, -1);
        n += hs + body;
      end while (n < budget);
      random_bytes += n;
    end

    // Closing part: drive one error into the sticky latch, then a few bytes
    // that must come back marked halted.
    wait_drain();
    in_gap_pct    = 0;
    out_stall_pct = 0;
    ending = ending_t'($urandom_range(0, 3));
    case (ending)
      END_SHORT: begin
        hs = $urandom_range(2, 12);
        program_setting(8'(hs), 8'd0, WC_2B, 1'($urandom), 1'b1, 32'hFFFF_FFFF);
        @(negedge clk);
        add_frame(64'($urandom_range(0, hs - 1)), 0, -1);
      end
      END_LONG: begin
        hs  = $urandom_range(4, 12);
        cap = hs + $urandom_range(0, 20);
        program_setting(8'(hs), 8'($urandom_range(0, hs - 4)), WC_4B, 1'($urandom),
                        1'b0, cap);
        @(negedge clk);
        add_frame(64'(cap - hs + $urandom_range(1, 200)), 0, -1);
      end
      END_WRAP: begin
        hs = $urandom_range(8, 20);
        program_setting(8'(hs), 8'($urandom_range(0, hs - 8)), WC_8B, 1'($urandom),
                        1'b0, 32'hFFFF_FFFF);
        @(negedge clk);
        add_frame(~64'd0 - 64'($urandom_range(0, hs - 1)), 0, -1);
      end
      default: begin
        program_setting(8'd255, 8'd0, WC_4B, 1'b1, 1'b0, 32'hFFFF_FFFF);
        case ($urandom_range(0, 3))
          0:       apb_write(REG_HDR_BYTES, 32'd1);        // header too small for field
          1:       apb_write(REG_WIDTH_CODE, 32'(WC_NONE));
          2:       apb_write(REG_LEN_POS, 32'd254);        // field runs past header
          default: apb_write(REG_MAX_FRAME, $urandom_range(1, 254));
        endcase
        @(negedge clk);
      end
    endcase
    repeat (8) pending_bytes.push_back(8'($urandom));

    wait_drain();
    repeat (8) @(posedge clk);  // room for any stray beat still in the pipeline
    $display("checked %0d beats, %0d frames closed, across %0d register settings",
             beats_checked, frames_closed, settings_done);
    $display("stream ended by %s, %0d beats seen in the latched error state",
             ending.name(), halted_beats);
    if (mismatches == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  // Run limit, far beyond the slowest legal run
  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/lffs_pkg.sv
rtl/core/lffs_tracker.sv
rtl/core/length_field_frame_splitter_core.sv
tb/length_field_frame_splitter_core_tb.sv
